### hw/rtl/rrt_tree_extend_core_macros.svh
// Assertion macros for the tree extend core checker.
`ifndef RRT_TREE_EXTEND_CORE_MACROS_SVH
`define RRT_TREE_EXTEND_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define RTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### hw/rtl/rte_pkg.sv
// Package: widths, codes and shared types of the tree extend core.
package rte_pkg;
	localparam int CoordW = 24;
	localparam int StepW = 23;
	localparam int IdxW = 10;
	localparam int CfgIdxW = 3;
	localparam int DefNodeCapacity = 1024;
	localparam int DiffW = 25;
	localparam int SqW = 50;
	localparam int SumW = 52;
	localparam int RadW = 64;
	localparam int RootW = 32;
	localparam int NumW = 55;
	localparam int QuoW = 56;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_FULL    = 2'd1,
		ST_ZERO    = 2'd2,
		ST_RESTART = 2'd3
	} status_t;

	localparam logic [CfgIdxW-1:0] REG_STEP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_THR = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SX = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SY = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SZ = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_GX = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_GY = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_GZ = 3'd7;

	typedef struct packed {
		logic root_wr;
		logic scan_start;
		logic scan_step;
		logic sqrt_start;
		logic sqrt_step;
		logic div_start;
		logic div_step;
		logic div_next_axis;
		logic node_wr;
		logic goal_start;
		logic load_out;
		logic [1:0] out_status;
	} rte_cmd_t;

	typedef struct packed {
		logic is_restart;
		logic full;
		logic scan_last;
		logic zero_dir;
		logic sqrt_done;
		logic div_done;
		logic div_last_axis;
		logic goal_done;
	} rte_stat_t;
endpackage

### hw/rtl/rte_stream_if.sv
// Valid/ready stream interfaces for input items and results.
interface rte_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [23:0] sample_x;
	logic signed [23:0] sample_y;
	logic signed [23:0] sample_z;
	modport source (output valid, cmd, sample_x, sample_y, sample_z, input ready);
	modport sink (input valid, cmd, sample_x, sample_y, sample_z, output ready);
endinterface

interface rte_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] new_x;
	logic signed [23:0] new_y;
	logic signed [23:0] new_z;
	logic [9:0] new_index;
	logic [9:0] parent_index;
	logic goal_reached;
	logic [1:0] status;
	modport source (output valid, new_x, new_y, new_z, new_index, parent_index,
		goal_reached, status, input ready);
	modport sink (input valid, new_x, new_y, new_z, new_index, parent_index,
		goal_reached, status, output ready);
endinterface

### hw/rtl/rte_ctrl.sv
// Controller state machine of the tree extend core.
module rte_ctrl import rte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rte_stat_t stat,
	output rte_cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DEC   = 10'b0000000010,
		S_SCAN  = 10'b0000000100,
		S_LAST  = 10'b0000001000,
		S_CHECK = 10'b0000010000,
		S_SQRT  = 10'b0000100000,
		S_DIV   = 10'b0001000000,
		S_WR    = 10'b0010000000,
		S_GOAL  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (stat.is_restart) begin
					cmd.root_wr = 1'b1;
					cmd.load_out = 1'b1;
					cmd.out_status = ST_RESTART;
					state_d = S_OUT;
				end else if (stat.full) begin
					cmd.load_out = 1'b1;
					cmd.out_status = ST_FULL;
					state_d = S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = S_LAST;
			end
			S_LAST: begin
				cmd.scan_step = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.zero_dir) begin
					cmd.load_out = 1'b1;
					cmd.out_status = ST_ZERO;
					state_d = S_OUT;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_done) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					if (stat.div_last_axis) state_d = S_WR;
					else cmd.div_next_axis = 1'b1;
				end
			end
			S_WR: begin
				cmd.node_wr = 1'b1;
				cmd.goal_start = 1'b1;
				state_d = S_GOAL;
			end
			S_GOAL: begin
				if (stat.goal_done) begin
					cmd.load_out = 1'b1;
					cmd.out_status = ST_ADDED;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

### hw/rtl/rte_dp.sv
// Datapath: node memory, nearest scan, square root, divider and goal test.
module rte_dp import rte_pkg::*; #(
	parameter int NodeCapacity = DefNodeCapacity
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_fire,
	input  logic                      in_cmd,
	input  logic signed [CoordW-1:0]  in_sx,
	input  logic signed [CoordW-1:0]  in_sy,
	input  logic signed [CoordW-1:0]  in_sz,
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_idx,
	input  logic [CoordW-1:0]         cfg_data,
	input  rte_cmd_t                  cmd,
	output rte_stat_t                 stat,
	output logic signed [CoordW-1:0]  o_x,
	output logic signed [CoordW-1:0]  o_y,
	output logic signed [CoordW-1:0]  o_z,
	output logic [IdxW-1:0]           o_new_idx,
	output logic [IdxW-1:0]           o_parent,
	output logic                      o_goal,
	output logic [1:0]                o_status
);
	localparam int AW = $clog2(NodeCapacity);
	localparam int CW = $clog2(NodeCapacity + 1);
	localparam int SW = (AW > IdxW) ? AW : IdxW;

	// configuration
	logic [StepW-1:0] step_q, thr_q;
	logic signed [CoordW-1:0] stx_q, sty_q, stz_q, gx_q, gy_q, gz_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepW'(196608);
			thr_q <= StepW'(655);
			stx_q <= CoordW'(131072);
			sty_q <= '0;
			stz_q <= -CoordW'(131072);
			gx_q <= '0;
			gy_q <= CoordW'(131072);
			gz_q <= CoordW'(131072);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STEP: step_q <= cfg_data[StepW-1:0];
				REG_THR:  thr_q <= cfg_data[StepW-1:0];
				REG_SX:   stx_q <= cfg_data;
				REG_SY:   sty_q <= cfg_data;
				REG_SZ:   stz_q <= cfg_data;
				REG_GX:   gx_q <= cfg_data;
				REG_GY:   gy_q <= cfg_data;
				REG_GZ:   gz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input item
	logic cmd_q;
	logic signed [CoordW-1:0] sx_q, sy_q, sz_q;
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_cmd;
			sx_q <= in_sx;
			sy_q <= in_sy;
			sz_q <= in_sz;
		end
	end

	// node count; root is written lazily into the rx/ry/rz root registers
	logic [CW-1:0] count_q;
	logic signed [CoordW-1:0] rx_q, ry_q, rz_q;
	logic root_init_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			root_init_q <= 1'b1;
		end else begin
			root_init_q <= 1'b0;
			if (cmd.root_wr) count_q <= CW'(1);
			else if (cmd.node_wr) count_q <= count_q + CW'(1);
		end
	end
	always_ff @(posedge clk) begin
		if (root_init_q || cmd.root_wr) begin
			rx_q <= stx_q;
			ry_q <= sty_q;
			rz_q <= stz_q;
		end
	end

	// node memory (entry 0 lives in rx/ry/rz)
	logic signed [CoordW-1:0] mem_x [NodeCapacity];
	logic signed [CoordW-1:0] mem_y [NodeCapacity];
	logic signed [CoordW-1:0] mem_z [NodeCapacity];
	logic [AW-1:0] rd_addr;
	logic signed [CoordW-1:0] rdx, rdy, rdz;
	logic signed [CoordW-1:0] nx_q, ny_q, nz_q;
	always_ff @(posedge clk) begin
		if (cmd.node_wr) begin
			mem_x[count_q[AW-1:0]] <= nx_q;
			mem_y[count_q[AW-1:0]] <= ny_q;
			mem_z[count_q[AW-1:0]] <= nz_q;
		end
		rdx <= mem_x[rd_addr];
		rdy <= mem_y[rd_addr];
		rdz <= mem_z[rd_addr];
	end

	// scan: address issued in the cycle before its compare
	logic [CW-1:0] scan_q;
	logic cmp_v_q, cmp_zero_q;
	logic [AW-1:0] cmp_idx_q;
	logic [SumW-1:0] best_d_q;
	logic [AW-1:0] best_q;
	logic signed [CoordW-1:0] bx_q, by_q, bz_q;
	logic have_q;
	assign rd_addr = scan_q[AW-1:0];

	logic signed [CoordW-1:0] cx, cy, cz;
	logic signed [DiffW-1:0] ex, ey, ez;
	logic [SumW-1:0] dsum;
	always_comb begin
		cx = cmp_zero_q ? rx_q : rdx;
		cy = cmp_zero_q ? ry_q : rdy;
		cz = cmp_zero_q ? rz_q : rdz;
		ex = DiffW'(sx_q) - DiffW'(cx);
		ey = DiffW'(sy_q) - DiffW'(cy);
		ez = DiffW'(sz_q) - DiffW'(cz);
		dsum = SumW'($unsigned(SqW'(ex) * SqW'(ex)))
			+ SumW'($unsigned(SqW'(ey) * SqW'(ey)))
			+ SumW'($unsigned(SqW'(ez) * SqW'(ez)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				have_q <= 1'b0;
				cmp_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cmp_v_q <= (scan_q < count_q);
				if (cmp_v_q) have_q <= 1'b1;
			end else cmp_v_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.scan_start) scan_q <= '0;
		else if (cmd.scan_step) scan_q <= scan_q + CW'(1);
		cmp_idx_q <= scan_q[AW-1:0];
		cmp_zero_q <= (scan_q == '0);
		if (cmp_v_q && (!have_q || dsum < best_d_q)) begin
			best_d_q <= dsum;
			best_q <= cmp_idx_q;
			bx_q <= cx;
			by_q <= cy;
			bz_q <= cz;
		end
	end

	// direction
	logic signed [DiffW-1:0] dx, dy, dz;
	assign dx = DiffW'(sx_q) - DiffW'(bx_q);
	assign dy = DiffW'(sy_q) - DiffW'(by_q);
	assign dz = DiffW'(sz_q) - DiffW'(bz_q);

	// integer square root of best_d * 4096, two bits per cycle
	logic [RadW-1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [RadW-1:0] rad_q;
	logic [5:0] sq_cnt_q;
	logic [RadW-1:0] trial;
	logic [RadW-1:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[RadW-3:0], rad_q[RadW-1 -: 2]};
		trial = {{(RadW-RootW){1'b0}}, root_q} << 2 | RadW'(1);
	end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rem_q <= '0;
			root_q <= '0;
			rad_q <= RadW'(best_d_q) << 12;
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step && sq_cnt_q != 6'd32) begin
			rad_q <= rad_q << 2;
			sq_cnt_q <= sq_cnt_q + 6'd1;
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	// rounding divide per axis: q = (2*num + n) / (2*n), restoring, one bit a cycle
	logic [1:0] axis_q;
	logic [5:0] dv_cnt_q;
	logic [QuoW:0] dv_rem_q;
	logic [QuoW-1:0] dv_num_q;
	logic signed [DiffW-1:0] dsel;
	logic [QuoW:0] dv_sh;
	logic [QuoW:0] dden;
	logic [QuoW-1:0] dv_nextnum;
	logic dv_bit;
	logic signed [CoordW-1:0] base;
	logic signed [QuoW+1:0] sum_full;
	logic signed [CoordW-1:0] sat;
	logic signed [QuoW+1:0] offs;
	// numerator of the axis loaded next
	logic [1:0] nax;
	logic signed [DiffW-1:0] dsel_n;
	logic [CoordW-1:0] dmag_n;
	logic [StepW+CoordW-1:0] prod_n;
	logic [QuoW-1:0] dnum_next;
	always_comb begin
		unique case (axis_q)
			2'd0: begin dsel = dx; base = bx_q; end
			2'd1: begin dsel = dy; base = by_q; end
			default: begin dsel = dz; base = bz_q; end
		endcase
		dden = (QuoW+1)'(root_q) << 1;
		dv_sh = {dv_rem_q[QuoW-1:0], dv_num_q[QuoW-1]};
		dv_bit = (dv_sh >= dden);
		dv_nextnum = {dv_num_q[QuoW-2:0], dv_bit};
		offs = dsel[DiffW-1] ? -(QuoW+2)'(dv_nextnum) : (QuoW+2)'(dv_nextnum);
		sum_full = (QuoW+2)'(base) + offs;
		if (sum_full > (QuoW+2)'(8388607)) sat = CoordW'(8388607);
		else if (sum_full < -(QuoW+2)'(8388608)) sat = CoordW'(-8388608);
		else sat = CoordW'(sum_full);
	end
	always_comb begin
		nax = cmd.div_start ? 2'd0 : axis_q + 2'd1;
		case (nax)
			2'd0: dsel_n = dx;
			2'd1: dsel_n = dy;
			default: dsel_n = dz;
		endcase
		dmag_n = dsel_n[DiffW-1] ? CoordW'(-dsel_n) : CoordW'(dsel_n);
		prod_n = step_q * dmag_n;
		dnum_next = (QuoW'(prod_n) << 7) + QuoW'(root_q);
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) axis_q <= '0;
		else if (cmd.div_next_axis) axis_q <= axis_q + 2'd1;
		if (cmd.div_start || cmd.div_next_axis) begin
			dv_cnt_q <= '0;
			dv_rem_q <= '0;
			dv_num_q <= dnum_next;
		end else if (cmd.div_step) begin
			dv_cnt_q <= dv_cnt_q + 6'd1;
			dv_rem_q <= dv_bit ? dv_sh - dden : dv_sh;
			dv_num_q <= dv_nextnum;
		end
		if (cmd.div_step && dv_cnt_q == 6'(QuoW-1)) begin
			unique case (axis_q)
				2'd0: nx_q <= sat;
				2'd1: ny_q <= sat;
				default: nz_q <= sat;
			endcase
		end
	end

	// goal test: one axis squared per cycle
	logic [1:0] g_cnt_q;
	logic [SumW-1:0] g_acc_q;
	logic signed [DiffW-1:0] gd;
	always_comb begin
		unique case (g_cnt_q)
			2'd0: gd = DiffW'(nx_q) - DiffW'(gx_q);
			2'd1: gd = DiffW'(ny_q) - DiffW'(gy_q);
			default: gd = DiffW'(nz_q) - DiffW'(gz_q);
		endcase
	end
	always_ff @(posedge clk) begin
		if (cmd.goal_start) begin
			g_cnt_q <= '0;
			g_acc_q <= '0;
		end else if (g_cnt_q != 2'd3) begin
			g_cnt_q <= g_cnt_q + 2'd1;
			g_acc_q <= g_acc_q + SumW'($unsigned(SqW'(gd) * SqW'(gd)));
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_status <= cmd.out_status;
			o_x <= '0; o_y <= '0; o_z <= '0;
			o_new_idx <= '0; o_parent <= '0; o_goal <= 1'b0;
			if (cmd.out_status == ST_RESTART) begin
				o_x <= stx_q; o_y <= sty_q; o_z <= stz_q;
			end else if (cmd.out_status == ST_ADDED) begin
				o_x <= nx_q; o_y <= ny_q; o_z <= nz_q;
				o_new_idx <= IdxW'(SW'(count_q - CW'(1)));
				o_parent <= IdxW'(SW'(best_q));
				o_goal <= (g_acc_q < SumW'(SumW'(thr_q) * SumW'(thr_q)));
			end
		end
	end

	assign stat.is_restart = cmd_q;
	assign stat.full = (count_q >= CW'(NodeCapacity));
	assign stat.scan_last = (scan_q >= count_q);
	assign stat.zero_dir = (best_d_q == '0);
	assign stat.sqrt_done = (sq_cnt_q == 6'd32);
	assign stat.div_done = (dv_cnt_q == 6'(QuoW-1));
	assign stat.div_last_axis = (axis_q == 2'd2);
	assign stat.goal_done = (g_cnt_q == 2'd3);
endmodule

### hw/rtl/rrt_tree_extend_core.sv
// Top level of the tree extend core.
// Path to result valid: restart or full table go from the decode state to the result;
// a zero direction adds the nearest-node scan; an extend adds the scan, the square root,
// three divides (one per axis) and the goal test; the scan visits one node per cycle.
// One item at a time; the next input transfer follows the result transfer.
// Reset sets the registers to their defaults and the tree to the root alone.
module rrt_tree_extend_core import rte_pkg::*; #(
	parameter int NodeCapacity = DefNodeCapacity
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [23:0]      cfg_data,
	rte_in_if.sink           in_ch,
	rte_out_if.source        out_ch
);
	rte_cmd_t cmd;
	rte_stat_t stat;

	rte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	rte_dp #(.NodeCapacity(NodeCapacity)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_ch.valid && in_ch.ready), .in_cmd(in_ch.cmd),
		.in_sx(in_ch.sample_x), .in_sy(in_ch.sample_y), .in_sz(in_ch.sample_z),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .stat(stat),
		.o_x(out_ch.new_x), .o_y(out_ch.new_y), .o_z(out_ch.new_z),
		.o_new_idx(out_ch.new_index), .o_parent(out_ch.parent_index),
		.o_goal(out_ch.goal_reached), .o_status(out_ch.status)
	);
endmodule

### hw/rtl/rte_checker.sv
// Port-level checker for the tree extend core, bound to the top level.
`include "rrt_tree_extend_core_macros.svh"
module rte_checker import rte_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [9:0]  new_index,
	input logic        goal_reached
);
	`RTE_ASSERT_IMP(a_one_item, clk, arst_n, out_valid, !in_ready)
	`RTE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`RTE_ASSERT_IMP(a_restart_idx, clk, arst_n, out_valid && status == ST_RESTART,
		new_index == '0 && !goal_reached)
	`RTE_ASSERT_IMP(a_full_zero, clk, arst_n,
		out_valid && (status == ST_FULL || status == ST_ZERO), !goal_reached)
endmodule

bind rrt_tree_extend_core rte_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .new_index(out_ch.new_index),
	.goal_reached(out_ch.goal_reached)
);
